@@ design/fxdk_pkg.sv @@
package fxdk_pkg;

  // Angles are counted in sixteenths of a degree.
  localparam int unsigned QUARTER   = 1440;
  localparam int unsigned EIGHTH    = 720;
  localparam int unsigned FULL_TURN = 5760;

  localparam int unsigned ANGLE_W = 13;
  localparam int unsigned QIDX_W  = 11;

  // Default fraction bits of the sine table.
  localparam int unsigned TRIG_FRAC_BITS_DEF = 15;

  // Configuration register indexes.
  localparam logic [1:0] REG_FIELD_ORIENTED = 2'd0;
  localparam logic [1:0] REG_X_SPEED_LIMIT  = 2'd1;
  localparam logic [1:0] REG_Y_SPEED_LIMIT  = 2'd2;
  localparam logic [1:0] REG_TURN_LIMIT     = 2'd3;

  localparam logic [11:0] SPEED_LIMIT_RST = 12'd1000;

  // Quadrant codes of the rotation angle.
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Division by 255 as a multiply by ceil(2^28 / 255); exact for numerators below 2^20.
  localparam logic [20:0] RECIP_255   = 21'd1052689;
  localparam int unsigned RECIP_SHIFT = 28;

  // Pi in Q2.30 and the Taylor divisors (2n)(2n+1) for n = 1..6.
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                                 64'd156};

  typedef logic [31:0] sine_rom_t [0:QUARTER];

  // Quarter-wave sine table, built at elaboration: Taylor series in Q2.30, then rounded
  // half up to frac_bits fraction bits.
  function automatic sine_rom_t build_sine_rom(int unsigned frac_bits);
    sine_rom_t       rom;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    int unsigned     sh;
    sh = 30 - frac_bits;
    for (int k = 0; k <= int'(QUARTER); k++) begin
      x    = (64'(k) * PI_Q30 + 64'd1440) / 64'd2880;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 0; n < 6; n++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[n];
        if (n[0] == 1'b0) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      rom[k] = 32'((acc + (longint'(1) << (sh - 1))) >>> sh);
    end
    return rom;
  endfunction

endpackage

@@ design/field_oriented_x_drive_kinematics.sv @@
// Channel   Dir  Bits  Contents (lowest bit first)
// s_axis    in   48    stick_x 7, stick_y 7, trigger_right 8, trigger_left 8, yaw_angle 13
// m_axis    out  64    wheel0_target 15, wheel1_target 15, wheel2_target 15, wheel3_target 15
// cfg       in   12    register index 2 bits, write data 12 bits, write enable
//
// One beat is taken in every cycle in which the output register is free or being emptied.
// Five register stages: input scaling, sine table read, products, sums, rounding into the
// output register. The quarter-wave sine table is a constant memory read at two addresses
// per cycle. Reset clears the stage valid bits and loads the register defaults; a stall
// freezes all stages together, so no beat is dropped or repeated.
module field_oriented_x_drive_kinematics #(
  parameter int unsigned TRIG_FRAC_BITS = fxdk_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // stick_x [6:0], stick_y [13:7], trigger_right [21:14], trigger_left [29:22],
  // yaw_angle [42:30], zero fill [47:43]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // wheel0_target [14:0], wheel1_target [29:15], wheel2_target [44:30],
  // wheel3_target [59:45], zero fill [63:60]
  output logic [63:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [11:0] cfg_data_i
);

  // Table entries run from 0 to 2^F, so they need one bit above the fraction.
  localparam int unsigned TW   = TRIG_FRAC_BITS + 1;
  localparam int unsigned SW   = TW + 1;           // signed sine or cosine
  localparam int unsigned VW   = 19;               // limit * (stick - 64)
  localparam int unsigned PW   = VW + SW;          // one product
  localparam int unsigned SUMW = PW + 1;           // sum of two products
  localparam int unsigned SH   = TRIG_FRAC_BITS + 6;
  localparam int unsigned AW   = fxdk_pkg::ANGLE_W;
  localparam int unsigned QW   = fxdk_pkg::QIDX_W;

  localparam fxdk_pkg::sine_rom_t SINE_ROM = fxdk_pkg::build_sine_rom(TRIG_FRAC_BITS);

  localparam logic signed [SUMW:0] HALF = $signed((SUMW + 1)'(1) << (SH - 1));

  localparam logic [AW-1:0] FULL_TURN_A = AW'(fxdk_pkg::FULL_TURN);
  localparam logic [AW-1:0] EIGHTH_A    = AW'(fxdk_pkg::EIGHTH);
  localparam logic [AW-1:0] QUARTER_A   = AW'(fxdk_pkg::QUARTER);
  localparam logic [AW-1:0] HALF_TURN_A = AW'(2 * fxdk_pkg::QUARTER);
  localparam logic [AW-1:0] THREE_Q_A   = AW'(3 * fxdk_pkg::QUARTER);

  // Configuration registers.
  logic        field_oriented_q;
  logic [11:0] x_lim_q, y_lim_q, turn_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_oriented_q <= 1'b1;
      x_lim_q          <= fxdk_pkg::SPEED_LIMIT_RST;
      y_lim_q          <= fxdk_pkg::SPEED_LIMIT_RST;
      turn_lim_q       <= fxdk_pkg::SPEED_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fxdk_pkg::REG_FIELD_ORIENTED: field_oriented_q <= cfg_data_i[0];
        fxdk_pkg::REG_X_SPEED_LIMIT:  x_lim_q          <= cfg_data_i;
        fxdk_pkg::REG_Y_SPEED_LIMIT:  y_lim_q          <= cfg_data_i;
        fxdk_pkg::REG_TURN_LIMIT:     turn_lim_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The whole pipeline advances together whenever the output register can move.
  logic ce;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  assign ce            = !v5_q || m_axis_tready;
  assign s_axis_tready = ce;
  assign m_axis_tvalid = v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (ce) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Stage 1: stick and trigger scaling, rotation angle.
  logic [6:0]         stick_x, stick_y;
  logic [7:0]         trig_r, trig_l, trig_mag;
  logic [AW-1:0]      yaw_in, yaw_m, ang_sum, ang_d;
  logic signed [7:0]  sx, sy;
  logic signed [20:0] nx_full, ny_full;
  logic [19:0]        rot_mag_d;

  assign stick_x = s_axis_tdata[6:0];
  assign stick_y = s_axis_tdata[13:7];
  assign trig_r  = s_axis_tdata[21:14];
  assign trig_l  = s_axis_tdata[29:22];
  assign yaw_in  = s_axis_tdata[42:30];

  assign sx       = $signed({1'b0, stick_x}) - 8'sd64;
  assign sy       = $signed({1'b0, stick_y}) - 8'sd64;
  assign nx_full  = $signed({1'b0, x_lim_q}) * sx;
  assign ny_full  = $signed({1'b0, y_lim_q}) * sy;
  assign trig_mag = (trig_l > trig_r) ? (trig_l - trig_r) : (trig_r - trig_l);
  assign rot_mag_d = 20'(turn_lim_q) * 20'(trig_mag);

  // Yaw wraps once at a full turn; adding the eighth turn wraps at most once more.
  assign yaw_m   = (yaw_in >= FULL_TURN_A) ? (yaw_in - FULL_TURN_A) : yaw_in;
  assign ang_sum = field_oriented_q ? (yaw_m + EIGHTH_A) : EIGHTH_A;
  assign ang_d   = (ang_sum >= FULL_TURN_A) ? (ang_sum - FULL_TURN_A) : ang_sum;

  logic signed [VW-1:0] nx1_q, ny1_q;
  logic [19:0]          rot_mag1_q;
  logic                 rot_neg1_q;
  logic [AW-1:0]        ang1_q;

  always_ff @(posedge clk_i) begin
    if (ce) begin
      nx1_q      <= nx_full[VW-1:0];
      ny1_q      <= ny_full[VW-1:0];
      rot_mag1_q <= rot_mag_d;
      rot_neg1_q <= trig_l > trig_r;
      ang1_q     <= ang_d;
    end
  end

  // Stage 2: quadrant split, sine table read, rotation divided by 255.
  logic [1:0]    quad_d;
  logic [AW-1:0] rem_wide;
  logic [QW-1:0] rem_idx, comp_idx;
  logic [40:0]   rot_prod;

  always_comb begin
    if (ang1_q >= THREE_Q_A) begin
      quad_d   = fxdk_pkg::QUAD_3;
      rem_wide = ang1_q - THREE_Q_A;
    end else if (ang1_q >= HALF_TURN_A) begin
      quad_d   = fxdk_pkg::QUAD_2;
      rem_wide = ang1_q - HALF_TURN_A;
    end else if (ang1_q >= QUARTER_A) begin
      quad_d   = fxdk_pkg::QUAD_1;
      rem_wide = ang1_q - QUARTER_A;
    end else begin
      quad_d   = fxdk_pkg::QUAD_0;
      rem_wide = ang1_q;
    end
  end

  assign rem_idx  = rem_wide[QW-1:0];
  assign comp_idx = QW'(fxdk_pkg::QUARTER) - rem_idx;
  assign rot_prod = 41'(rot_mag1_q) * 41'(fxdk_pkg::RECIP_255);

  logic [TW-1:0]        tab_r_q, tab_c_q;   // sin(rem) and sin(quarter - rem)
  logic [1:0]           quad2_q;
  logic signed [VW-1:0] nx2_q, ny2_q;
  logic [11:0]          rot_quo2_q;
  logic                 rot_neg2_q;

  always_ff @(posedge clk_i) begin
    if (ce) begin
      tab_r_q    <= SINE_ROM[rem_idx][TW-1:0];
      tab_c_q    <= SINE_ROM[comp_idx][TW-1:0];
      quad2_q    <= quad_d;
      nx2_q      <= nx1_q;
      ny2_q      <= ny1_q;
      rot_quo2_q <= rot_prod[fxdk_pkg::RECIP_SHIFT +: 12];
      rot_neg2_q <= rot_neg1_q;
    end
  end

  // Stage 3: sine and cosine by quadrant, four products.
  logic signed [SW-1:0] tab_r_s, tab_c_s, sin_v, cos_v;
  logic signed [12:0]   rot_s;

  assign tab_r_s = $signed({1'b0, tab_r_q});
  assign tab_c_s = $signed({1'b0, tab_c_q});
  assign rot_s   = rot_neg2_q ? -$signed({1'b0, rot_quo2_q}) : $signed({1'b0, rot_quo2_q});

  always_comb begin
    case (quad2_q)
      fxdk_pkg::QUAD_0: begin
        sin_v = tab_r_s;
        cos_v = tab_c_s;
      end
      fxdk_pkg::QUAD_1: begin
        sin_v = tab_c_s;
        cos_v = -tab_r_s;
      end
      fxdk_pkg::QUAD_2: begin
        sin_v = -tab_r_s;
        cos_v = -tab_c_s;
      end
      default: begin
        sin_v = -tab_c_s;
        cos_v = tab_r_s;
      end
    endcase
  end

  logic signed [PW-1:0] p_xc_q, p_ys_q, p_yc_q, p_xs_q;
  logic signed [12:0]   rot3_q;

  always_ff @(posedge clk_i) begin
    if (ce) begin
      p_xc_q <= nx2_q * cos_v;
      p_ys_q <= ny2_q * sin_v;
      p_yc_q <= ny2_q * cos_v;
      p_xs_q <= nx2_q * sin_v;
      rot3_q <= rot_s;
    end
  end

  // Stage 4: the two rotated components.
  logic signed [SUMW-1:0] pc_q, ps_q;
  logic signed [12:0]     rot4_q;

  always_ff @(posedge clk_i) begin
    if (ce) begin
      pc_q   <= SUMW'(p_xc_q) + SUMW'(p_ys_q);
      ps_q   <= SUMW'(p_yc_q) - SUMW'(p_xs_q);
      rot4_q <= rot3_q;
    end
  end

  // Stage 5: round to mm/s (halves upward), add rotation, into the output register.
  logic signed [SUMW:0] pc_e, ps_e, rnd0, rnd1, rnd2, rnd3;
  logic signed [14:0]   rot15;
  logic [14:0]          w0, w1, w2, w3;

  assign pc_e  = (SUMW + 1)'(pc_q);
  assign ps_e  = (SUMW + 1)'(ps_q);
  assign rnd0  = (pc_e + HALF) >>> SH;
  assign rnd1  = (ps_e + HALF) >>> SH;
  assign rnd2  = (HALF - pc_e) >>> SH;
  assign rnd3  = (HALF - ps_e) >>> SH;
  assign rot15 = 15'(rot4_q);
  assign w0    = rnd0[14:0] + rot15;
  assign w1    = rnd1[14:0] + rot15;
  assign w2    = rnd2[14:0] + rot15;
  assign w3    = rnd3[14:0] + rot15;

  logic [59:0] out_q;

  always_ff @(posedge clk_i) begin
    if (ce) begin
      out_q <= {w3, w2, w1, w0};
    end
  end

  assign m_axis_tdata = {4'd0, out_q};

`ifndef SYNTHESIS
  // An accepted beat always lands in the first stage.
  a_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v1_q)
    else $error("accepted beat missing from first stage");

  // A stall freezes every internal stage.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ce |=> $stable({v1_q, v2_q, v3_q, v4_q}))
    else $error("internal stage moved during stall");

  // The wrapped angle stays below a full turn.
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> ang1_q < FULL_TURN_A)
    else $error("rotation angle out of range");

  // Table reads never exceed unity and the two reads are complementary angles.
  a_table_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> tab_r_q <= (TW'(1) << TRIG_FRAC_BITS) && tab_c_q <= (TW'(1) << TRIG_FRAC_BITS))
    else $error("sine table value above unity");
`endif

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned FRAC_BITS = fxdk_pkg::TRIG_FRAC_BITS_DEF;
  // The velocity part is a numerator over 64 * 2^FRAC_BITS, so it is rounded by this shift.
  localparam int unsigned WHEEL_SHIFT = FRAC_BITS + 6;
  localparam int unsigned TABLE_SHIFT = 30 - FRAC_BITS;
  // Longest correct silence is the forced receiver hold-off; this is several times that.
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned PHASE_BEATS     = 80;
  localparam int unsigned NUM_DIRECTED    = 20;
  localparam int unsigned REPORT_CAP      = 200;

  // Four wheel targets, wheel 0 in the lowest bits, exactly as they sit in m_axis_tdata.
  typedef logic [3:0][14:0] wheel_set_t;

  // One directed command. Where all four wheels are known at a glance the value is typed in.
  typedef struct {
    int stick_x;
    int stick_y;
    int trig_r;
    int trig_l;
    int yaw;
    bit typed;
    int typed_val;
  } cmd_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // stick_x [6:0], stick_y [13:7], trigger_right [21:14], trigger_left [29:22],
  // yaw_angle [42:30], zero fill [47:43]
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // wheel0_target [14:0], wheel1_target [29:15], wheel2_target [44:30],
  // wheel3_target [59:45], zero fill [63:60]
  logic [63:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [11:0] cfg_data_i;

  // Our own copy of the register file, updated whenever the testbench writes a register.
  bit          cfg_field_oriented;
  logic [11:0] cfg_x_limit;
  logic [11:0] cfg_y_limit;
  logic [11:0] cfg_turn_limit;

  // Quarter-wave sine table in Q1.FRAC_BITS, index in sixteenths of a degree.
  longint      sine_quarter [0:fxdk_pkg::QUARTER];

  wheel_set_t  wheel_targets_q [$];

  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  bit          hold_off_req;
  bit          beat_typed;
  int          beat_typed_val;
  int unsigned error_count;
  int unsigned silent_cycles;

  field_oriented_x_drive_kinematics #(
    .TRIG_FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // The sine table is the integer Taylor series of the angle in Q2.30, up to the x^13 term,
  // each product truncated by a shift and each term divided with truncation, then rounded
  // half up to the table's fraction bits.
  initial begin
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    for (int k = 0; k <= int'(fxdk_pkg::QUARTER); k++) begin
      x    = (longint'(k) * fxdk_pkg::PI_Q30 + 64'd1440) / 64'd2880;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 6; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      sine_quarter[k] = (acc + (longint'(1) <<< (TABLE_SHIFT - 1))) >>> TABLE_SHIFT;
    end
  end

  // Works out the four wheel targets of one input beat under the current register settings.
  // The stick terms stay exact as numerators over 64 until the final rounding, which is
  // floor(v + 1/2) on each wheel separately; the trigger term is truncated towards zero.
  function automatic wheel_set_t predict_wheel_targets(logic [47:0] beat);
    longint      sx;
    longint      sy;
    longint      trig_diff;
    longint      nx;
    longint      ny;
    longint      rot;
    longint      s;
    longint      c;
    longint      pc;
    longint      ps;
    longint      half;
    int unsigned yaw;
    int unsigned angle;
    int unsigned rem;
    logic [1:0]  quad;
    wheel_set_t  w;
    sx        = longint'(beat[6:0]) - 64;
    sy        = longint'(beat[13:7]) - 64;
    trig_diff = longint'(beat[21:14]) - longint'(beat[29:22]);
    // Headings past a full turn simply wrap round.
    yaw       = int'(beat[42:30]) % fxdk_pkg::FULL_TURN;
    nx        = longint'(cfg_x_limit) * sx;
    ny        = longint'(cfg_y_limit) * sy;
    rot       = (longint'(cfg_turn_limit) * trig_diff) / 255;
    // In the robot frame the heading plays no part at all.
    angle     = cfg_field_oriented ? (fxdk_pkg::EIGHTH + yaw) % fxdk_pkg::FULL_TURN
                                   : fxdk_pkg::EIGHTH;
    quad      = 2'(angle / fxdk_pkg::QUARTER);
    rem       = angle % fxdk_pkg::QUARTER;
    case (quad)
      fxdk_pkg::QUAD_0: begin
        s = sine_quarter[rem];
        c = sine_quarter[fxdk_pkg::QUARTER - rem];
      end
      fxdk_pkg::QUAD_1: begin
        s = sine_quarter[fxdk_pkg::QUARTER - rem];
        c = -sine_quarter[rem];
      end
      fxdk_pkg::QUAD_2: begin
        s = -sine_quarter[rem];
        c = -sine_quarter[fxdk_pkg::QUARTER - rem];
      end
      default: begin
        s = -sine_quarter[fxdk_pkg::QUARTER - rem];
        c = sine_quarter[rem];
      end
    endcase
    pc   = nx * c + ny * s;
    ps   = ny * c - nx * s;
    half = longint'(1) <<< (WHEEL_SHIFT - 1);
    w[0] = 15'(((pc + half) >>> WHEEL_SHIFT) + rot);
    w[1] = 15'(((ps + half) >>> WHEEL_SHIFT) + rot);
    w[2] = 15'(((-pc + half) >>> WHEEL_SHIFT) + rot);
    w[3] = 15'(((-ps + half) >>> WHEEL_SHIFT) + rot);
    return w;
  endfunction

  // Everything is sampled at the rising edge, where all inputs have been steady since the
  // falling edge. An accepted input beat queues its expectation before any output beat of
  // the same edge is checked; the pipeline latency keeps the two apart anyway.
  always @(posedge clk_i) begin
    wheel_set_t exp_w;
    wheel_set_t got_w;
    if (s_axis_tvalid && s_axis_tready) begin
      if (beat_typed) begin
        for (int i = 0; i < 4; i++) begin
          exp_w[i] = 15'(beat_typed_val);
        end
      end else begin
        exp_w = predict_wheel_targets(s_axis_tdata);
      end
      wheel_targets_q.push_back(exp_w);
    end
    if (m_axis_tvalid && m_axis_tready) begin
      got_w = m_axis_tdata[59:0];
      if (wheel_targets_q.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_CAP) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time,
                   m_axis_tdata);
        end
      end else begin
        exp_w = wheel_targets_q.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (got_w[i] !== exp_w[i]) begin
            error_count++;
            if (error_count <= REPORT_CAP) begin
              $display("%0t: wheel%0d_target mismatch, expected %0d, actual %0d", $time, i,
                       $signed(exp_w[i]), $signed(got_w[i]));
            end
          end
        end
      end
    end
    // Watchdog: a long run of edges with no beat on either side means the block has hung.
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      silent_cycles = 0;
    end else begin
      silent_cycles++;
    end
    if (silent_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, silent_cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: stalls at random per the current phase. A hold-off request keeps tready low
  // for a long stretch so that the pipeline fills and the input side has to back off.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Offers one command beat, with random idle cycles ahead of it, and waits until the block
  // has taken it. Returns at the falling edge after acceptance with tvalid still high, so a
  // following beat goes out back to back.
  task automatic send_command(input logic [47:0] beat, input bit typed, input int typed_val);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid  <= 1'b1;
    s_axis_tdata   <= beat;
    beat_typed     = typed;
    beat_typed_val = typed_val;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Lowers tvalid and waits until every expected result has come out, then lets the
  // pipeline settle for longer than its latency.
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (wheel_targets_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [11:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
  endtask

  // Writes all four registers back to back while the block is idle. The mode register gets
  // random upper bits, which the block must ignore.
  task automatic load_drive_settings(input bit fo, input logic [11:0] x_lim,
                                     input logic [11:0] y_lim, input logic [11:0] turn_lim);
    write_register(fxdk_pkg::REG_FIELD_ORIENTED, {11'($urandom), fo});
    write_register(fxdk_pkg::REG_X_SPEED_LIMIT, x_lim);
    write_register(fxdk_pkg::REG_Y_SPEED_LIMIT, y_lim);
    write_register(fxdk_pkg::REG_TURN_LIMIT, turn_lim);
    cfg_we_i <= 1'b0;
    cfg_field_oriented = fo;
    cfg_x_limit        = x_lim;
    cfg_y_limit        = y_lim;
    cfg_turn_limit     = turn_lim;
    @(negedge clk_i);
  endtask

  initial begin
    cmd_row_t    cmd_rows [NUM_DIRECTED];
    int          stick_x;
    int          stick_y;
    int          trig_r;
    int          trig_l;
    int          yaw;
    bit          fo;
    logic [11:0] x_lim;
    logic [11:0] y_lim;
    logic [11:0] turn_lim;

    // Every input of the block is known from time zero.
    rst_ni             = 1'b0;
    s_axis_tvalid      = 1'b0;
    s_axis_tdata       = '0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = fxdk_pkg::REG_FIELD_ORIENTED;
    cfg_data_i         = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_off_req       = 1'b0;
    beat_typed         = 1'b0;
    beat_typed_val     = 0;
    error_count        = 0;
    silent_cycles      = 0;
    // Register values straight after reset.
    cfg_field_oriented = 1'b1;
    cfg_x_limit        = fxdk_pkg::SPEED_LIMIT_RST;
    cfg_y_limit        = fxdk_pkg::SPEED_LIMIT_RST;
    cfg_turn_limit     = fxdk_pkg::SPEED_LIMIT_RST;

    // Directed commands under the reset settings. With both sticks centred only the trigger
    // term is left, so those rows are typed in: nothing, full right turn, full left turn, both full.
    cmd_rows = '{
      '{64, 64, 0, 0, 0, 1'b1, 0},
      '{64, 64, 255, 0, 0, 1'b1, 1000},
      '{64, 64, 0, 255, 5759, 1'b1, -1000},
      '{64, 64, 255, 255, 8191, 1'b1, 0},
      '{0, 64, 0, 0, 0, 1'b0, 0},
      '{127, 64, 0, 0, 0, 1'b0, 0},
      '{64, 0, 0, 0, 0, 1'b0, 0},
      '{64, 127, 0, 0, 0, 1'b0, 0},
      '{0, 0, 0, 0, 720, 1'b0, 0},
      '{127, 127, 0, 0, 1440, 1'b0, 0},
      '{0, 127, 0, 0, 2160, 1'b0, 0},
      '{127, 0, 0, 0, 2880, 1'b0, 0},
      '{127, 64, 0, 0, 4320, 1'b0, 0},
      '{0, 64, 0, 0, 5040, 1'b0, 0},
      '{127, 127, 0, 0, 5759, 1'b0, 0},
      '{127, 127, 0, 0, 5760, 1'b0, 0},
      '{0, 0, 0, 0, 8191, 1'b0, 0},
      '{127, 0, 255, 0, 3000, 1'b0, 0},
      '{100, 30, 200, 17, 1000, 1'b0, 0},
      '{10, 120, 3, 250, 6000, 1'b0, 0}
    };

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    foreach (cmd_rows[i]) begin
      send_command({5'b0, 13'(cmd_rows[i].yaw), 8'(cmd_rows[i].trig_l),
                    8'(cmd_rows[i].trig_r), 7'(cmd_rows[i].stick_y),
                    7'(cmd_rows[i].stick_x)},
                   cmd_rows[i].typed, cmd_rows[i].typed_val);
    end

    // Random phases. Each one starts from an empty pipeline, loads new settings (the
    // extremes among them) and picks its own pattern of idle and stall cycles.
    for (int p = 0; p < 6; p++) begin
      wait_for_drain();
      case (p)
        0: begin
          fo = 1'b1; x_lim = fxdk_pkg::SPEED_LIMIT_RST; y_lim = fxdk_pkg::SPEED_LIMIT_RST;
          turn_lim = fxdk_pkg::SPEED_LIMIT_RST;
          sender_idle_pct = 0; receiver_stall_pct = 0;
        end
        1: begin
          fo = 1'b0; x_lim = 12'hFFF; y_lim = 12'hFFF; turn_lim = 12'hFFF;
          sender_idle_pct = 48; receiver_stall_pct = 0;
        end
        2: begin
          fo = 1'b1; x_lim = '0; y_lim = '0; turn_lim = '0;
          sender_idle_pct = 0; receiver_stall_pct = 48;
        end
        3: begin
          fo = 1'b1; x_lim = 12'($urandom); y_lim = 12'($urandom);
          turn_lim = 12'($urandom);
          sender_idle_pct = 9; receiver_stall_pct = 9;
        end
        4: begin
          fo = 1'b0; x_lim = 12'($urandom); y_lim = 12'($urandom);
          turn_lim = 12'($urandom);
          sender_idle_pct = 48; receiver_stall_pct = 48;
        end
        default: begin
          fo = 1'b1; x_lim = 12'hFFF; y_lim = 12'($urandom); turn_lim = 12'hFFF;
          sender_idle_pct = 0; receiver_stall_pct = 48;
        end
      endcase
      load_drive_settings(fo, x_lim, y_lim, turn_lim);

      for (int i = 0; i < int'(PHASE_BEATS); i++) begin
        // Midway through the first phase the receiver holds off while beats keep coming,
        // so the stages fill and the block must stall its input without losing anything.
        if (p == 0 && i == int'(PHASE_BEATS) / 2) begin
          hold_off_req = 1'b1;
        end
        // Midway through the fourth phase the sender stops until the pipeline has emptied.
        if (p == 3 && i == int'(PHASE_BEATS) / 2) begin
          wait_for_drain();
        end
        // Stick and trigger ends turn up now and then; headings cover all 13 bits, so
        // values past a full turn are included.
        stick_x = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 127 : 0)
                                           : $urandom_range(127);
        stick_y = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 127 : 0)
                                           : $urandom_range(127);
        trig_r  = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 255 : 0)
                                           : $urandom_range(255);
        trig_l  = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 255 : 0)
                                           : $urandom_range(255);
        yaw     = $urandom_range(8191);
        send_command({5'b0, 13'(yaw), 8'(trig_l), 8'(trig_r), 7'(stick_y), 7'(stick_x)},
                     1'b0, 0);
      end
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
